/* rtl/fma_pkg.sv */
// Package for the free-extent map allocator.
// Widths, command and status codes, register indexes, datapath command struct.
package fma_pkg;
  localparam int MAP_ENTRIES = 64;
  localparam int ADDR_BITS   = 16;
  localparam int IDX_BITS    = $clog2(MAP_ENTRIES);
  localparam int CNT_BITS    = $clog2(MAP_ENTRIES + 1);
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_FIT_MODE  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_POOL_BASE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_POOL_SIZE = 2'd2;

  typedef logic [ADDR_BITS-1:0] val_t;
  typedef logic [IDX_BITS-1:0]  idx_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  // datapath operations
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1; // read entry at idx
  localparam logic [2:0] OP_WRITE = 3'd2; // write addr/size at idx
  localparam logic [2:0] OP_MOVE  = 3'd3; // write held read data at idx

  typedef struct packed {
    logic [2:0] op;
    idx_t       idx;
    val_t       wa;
    val_t       ws;
  } mem_cmd_t;

  typedef struct packed {
    val_t ra;
    val_t rs;
  } mem_sts_t;
endpackage

/* rtl/fma_if.sv */
// Valid/ready channel interfaces for the allocator.
// Depends on fma_pkg.
interface fma_in_if;
  import fma_pkg::*;
  logic valid;
  logic ready;
  logic cmd;
  val_t addr;
  val_t size;
  modport source (output valid, cmd, addr, size, input ready);
  modport sink (input valid, cmd, addr, size, output ready);
endinterface

interface fma_out_if;
  import fma_pkg::*;
  logic valid;
  logic ready;
  val_t alloc_addr;
  logic [1:0] status;
  logic [6:0] extent_count;
  modport source (output valid, alloc_addr, status, extent_count, input ready);
  modport sink (input valid, alloc_addr, status, extent_count, output ready);
endinterface

/* rtl/fma_table.sv */
// Extent table datapath: address and size memories with registered read.
// Depends on fma_pkg.
module fma_table (
  input  logic              clk,
  input  fma_pkg::mem_cmd_t cmd,
  output fma_pkg::mem_sts_t sts
);
  import fma_pkg::*;
  val_t mem_a [MAP_ENTRIES];
  val_t mem_s [MAP_ENTRIES];

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_READ: begin
        sts.ra <= mem_a[cmd.idx];
        sts.rs <= mem_s[cmd.idx];
      end
      OP_WRITE: begin
        mem_a[cmd.idx] <= cmd.wa;
        mem_s[cmd.idx] <= cmd.ws;
      end
      OP_MOVE: begin
        mem_a[cmd.idx] <= sts.ra;
        mem_s[cmd.idx] <= sts.rs;
      end
      default: ;
    endcase
  end
endmodule

/* rtl/fma_ctrl.sv */
// Allocator controller: scans the table, chooses a fit, shifts entries.
// Depends on fma_pkg; drives fma_table through mem_cmd_t.
module fma_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fma_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [fma_pkg::CFG_DATA_BITS-1:0] cfg_data,
  fma_in_if.sink                          in_ch,
  fma_out_if.source                       out_ch,
  output fma_pkg::mem_cmd_t               mcmd,
  input  fma_pkg::mem_sts_t               msts
);
  import fma_pkg::*;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_AUPD  = 4'd4;
  localparam logic [3:0] S_DEL   = 4'd5;
  localparam logic [3:0] S_DELW  = 4'd6;
  localparam logic [3:0] S_FSCAN = 4'd7;
  localparam logic [3:0] S_FCHK  = 4'd8;
  localparam logic [3:0] S_FNXT  = 4'd9;
  localparam logic [3:0] S_FDEC  = 4'd10;
  localparam logic [3:0] S_INS   = 4'd11;
  localparam logic [3:0] S_INSW  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state;
  logic       fit_mode;
  val_t       pool_base, pool_size;
  cnt_t       total;
  val_t       rq_addr, rq_size;
  cnt_t       i;
  logic       found;
  idx_t       pick;
  val_t       pick_a, pick_s;
  val_t       prev_a, prev_s;
  logic       has_prev;
  val_t       res_addr;
  logic [1:0] res_st;

  logic [ADDR_BITS:0] prev_end, free_end, sum1, sum2, sum3;
  val_t sat1, sat2, sat3;
  logic better;

  assign prev_end = {1'b0, prev_a} + {1'b0, prev_s};
  assign free_end = {1'b0, rq_addr} + {1'b0, rq_size};
  assign sum1 = {1'b0, prev_s} + {1'b0, rq_size};
  assign sat1 = sum1[ADDR_BITS] ? '1 : sum1[ADDR_BITS-1:0];
  assign sum2 = {1'b0, sat1} + {1'b0, msts.rs};
  assign sat2 = sum2[ADDR_BITS] ? '1 : sum2[ADDR_BITS-1:0];
  assign sum3 = {1'b0, msts.rs} + {1'b0, rq_size};
  assign sat3 = sum3[ADDR_BITS] ? '1 : sum3[ADDR_BITS-1:0];
  assign better = fit_mode ? (msts.rs > pick_s) : (msts.rs < pick_s);

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.alloc_addr = res_addr;
  assign out_ch.status = res_st;
  assign out_ch.extent_count = 7'(total);

  always_comb begin
    mcmd = '{op: OP_NONE, idx: i[IDX_BITS-1:0], wa: rq_addr, ws: rq_size};
    case (state)
      S_LOAD: begin
        mcmd.op = OP_WRITE;
        mcmd.idx = '0;
        mcmd.wa = pool_base;
        mcmd.ws = pool_size;
      end
      S_SCAN, S_FSCAN: mcmd.op = OP_READ;
      S_AUPD: begin
        mcmd.op = OP_WRITE;
        mcmd.idx = pick;
        mcmd.wa = pick_a + rq_size;
        mcmd.ws = pick_s - rq_size;
      end
      S_DEL: begin
        mcmd.op = OP_READ;
        mcmd.idx = IDX_BITS'(i + cnt_t'(1));
      end
      S_DELW: mcmd.op = OP_MOVE;
      S_FNXT: begin
        mcmd.op = OP_WRITE;
        mcmd.idx = pick;
        mcmd.wa = pick_a;
        mcmd.ws = pick_s;
      end
      S_FDEC: begin
        if (i == '0) begin
          mcmd.op = OP_NONE;
        end else begin
          mcmd.op = OP_READ;
          mcmd.idx = IDX_BITS'(i - cnt_t'(1));
        end
      end
      S_INSW: mcmd.op = OP_MOVE;
      S_INS: mcmd.op = OP_WRITE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      fit_mode <= 1'b0;
      pool_base <= '0;
      pool_size <= val_t'(4096);
      total <= cnt_t'(1);
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_FIT_MODE: fit_mode <= cfg_data[0];
          REG_POOL_BASE: begin
            pool_base <= cfg_data;
            total <= (pool_size != '0) ? cnt_t'(1) : '0;
            state <= S_LOAD;
          end
          REG_POOL_SIZE: begin
            pool_size <= cfg_data;
            total <= (cfg_data != '0) ? cnt_t'(1) : '0;
            state <= S_LOAD;
          end
          default: ;
        endcase
      end else begin
        case (state)
          S_LOAD: state <= S_IDLE;
          S_IDLE: if (in_ch.valid) begin
            rq_addr <= in_ch.addr;
            rq_size <= in_ch.size;
            i <= '0;
            found <= 1'b0;
            has_prev <= 1'b0;
            res_addr <= '0;
            res_st <= ST_DONE;
            if (in_ch.cmd == CMD_ALLOC) begin
              state <= (total == '0) ? S_CHK : S_SCAN;
            end else if (in_ch.size == '0) begin
              state <= S_OUT;
            end else begin
              state <= (total == '0) ? S_FCHK : S_FSCAN;
            end
          end
          S_SCAN: state <= S_CHK;
          S_CHK: begin
            if (i != total) begin
              if (msts.rs >= rq_size && (!found || better)) begin
                found <= 1'b1;
                pick <= i[IDX_BITS-1:0];
                pick_a <= msts.ra;
                pick_s <= msts.rs;
              end
              i <= i + cnt_t'(1);
              state <= (i + cnt_t'(1) == total) ? S_CHK : S_SCAN;
            end else if (!found) begin
              res_st <= ST_NOFIT;
              state <= S_OUT;
            end else begin
              res_addr <= pick_a;
              state <= S_AUPD;
            end
          end
          S_AUPD: begin
            if (pick_s == rq_size) begin
              i <= cnt_t'(pick);
              total <= total - cnt_t'(1);
              state <= S_DEL;
            end else begin
              state <= S_OUT;
            end
          end
          // total already decremented: shift while i < total
          S_DEL: state <= (i < total) ? S_DELW : S_OUT;
          S_DELW: begin
            i <= i + cnt_t'(1);
            state <= S_DEL;
          end
          S_FSCAN: state <= S_FCHK;
          S_FCHK: begin
            if (i != total && msts.ra < rq_addr) begin
              has_prev <= 1'b1;
              prev_a <= msts.ra;
              prev_s <= msts.rs;
              i <= i + cnt_t'(1);
              state <= (i + cnt_t'(1) == total) ? S_FCHK : S_FSCAN;
            end else begin
              // i is k; msts holds entry k when i < total
              if (has_prev && prev_end == {1'b0, rq_addr}) begin
                pick <= IDX_BITS'(i - cnt_t'(1));
                rq_addr <= prev_a;
                if (i != total && free_end == {1'b0, msts.ra}) begin
                  rq_size <= sat2;
                  // write merged at k-1 then remove k
                  pick_a <= prev_a;
                  pick_s <= sat2;
                end else begin
                  rq_size <= sat1;
                  pick_a <= prev_a;
                  pick_s <= sat1;
                end
                found <= (i != total && free_end == {1'b0, msts.ra});
                state <= S_FNXT;
              end else if (i != total && free_end == {1'b0, msts.ra}) begin
                pick <= i[IDX_BITS-1:0];
                found <= 1'b0;
                pick_a <= rq_addr;
                pick_s <= sat3;
                state <= S_FNXT;
              end else if (total >= cnt_t'(MAP_ENTRIES)) begin
                res_st <= ST_FULL;
                state <= S_OUT;
              end else begin
                pick <= i[IDX_BITS-1:0];
                i <= total;
                total <= total + cnt_t'(1);
                state <= S_FDEC;
              end
            end
          end
          // merge write through the datapath write, as in AUPD; on a two-sided merge, then remove entry k
          S_FNXT: begin
            state <= S_OUT;
            if (found) begin
              i <= cnt_t'(pick) + cnt_t'(1);
              total <= total - cnt_t'(1);
              state <= S_DEL;
            end
          end
          S_FDEC: begin
            if (i == cnt_t'(pick)) begin
              state <= S_INS;
            end else begin
              state <= S_INSW;
            end
          end
          S_INSW: begin
            i <= i - cnt_t'(1);
            state <= S_FDEC;
          end
          S_INS: state <= S_OUT;
          S_OUT: if (out_ch.ready) state <= S_IDLE;
          default: state <= S_IDLE;
        endcase
      end
    end
  end
endmodule

/* rtl/free_map_allocator_best_worst_fit_top.sv */
// Free-extent map allocator top level: controller plus table datapath.
// The fit scan and the free search read the held extents in turn, and a delete
// or an insert shifts the table entries one by one.
// One item at a time; the table memory port sets the pace.
// Reset (synchronous): best fit, pool 0..4095 loaded as the only extent.
// Depends on fma_pkg, fma_if, fma_table, fma_ctrl.
module free_map_allocator_best_worst_fit_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fma_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [fma_pkg::CFG_DATA_BITS-1:0] cfg_data,
  fma_in_if.sink                            in_ch,
  fma_out_if.source                         out_ch
);
  import fma_pkg::*;
  mem_cmd_t mcmd;
  mem_sts_t msts;

  fma_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch), .mcmd(mcmd), .msts(msts)
  );

  fma_table u_table (.clk(clk), .cmd(mcmd), .sts(msts));
endmodule

/* tb/free_map_allocator_best_worst_fit_top_test.sv */
// Testbench for the free-extent map allocator: directed and random allocate/free
// transactions checked against an in-bench extent table predictor.
// Depends on fma_pkg, fma_if and free_map_allocator_best_worst_fit_top.
`timescale 1ns / 1ps
module free_map_allocator_best_worst_fit_top_test;
  import fma_pkg::*;

  typedef struct packed {
    val_t       alloc_addr;
    logic [1:0] status;
    logic [6:0] extent_count;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  fma_in_if in_ch();
  fma_out_if out_ch();

  free_map_allocator_best_worst_fit_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // predictor copy of the free-extent table
  logic fit_worst;
  val_t base_reg, size_reg;
  val_t ext_a[MAP_ENTRIES];
  val_t ext_s[MAP_ENTRIES];
  int   ext_n;

  grant_t grants_due[$];
  int  errors = 0;
  int  idle_pct = 9;
  int  stall_cnt = 0;
  int  n_results = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_ALLOC;
    in_ch.addr = '0;
    in_ch.size = '0;
    out_ch.ready = 1'b0;
  end

  function automatic void reload_pool();
    ext_a[0] = base_reg;
    ext_s[0] = size_reg;
    ext_n = (size_reg != 0) ? 1 : 0;
  endfunction

  function automatic void drop_extent(int k);
    for (int i = k; i + 1 < ext_n; i++) begin
      ext_a[i] = ext_a[i+1];
      ext_s[i] = ext_s[i+1];
    end
    ext_n--;
  endfunction

  function automatic val_t sat_sum(val_t a, val_t b);
    logic [ADDR_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ADDR_BITS] ? '1 : s[ADDR_BITS-1:0];
  endfunction

  function automatic grant_t predict_grant(logic cmd, val_t a, val_t sz);
    grant_t g;
    int pick, k;
    logic found, prev_adj, next_adj;
    g = '0;
    if (cmd == CMD_ALLOC) begin
      found = 1'b0;
      pick = 0;
      for (int i = 0; i < ext_n; i++) begin
        if (ext_s[i] >= sz) begin
          if (!found) begin
            pick = i;
            found = 1'b1;
          end else if (fit_worst ? ext_s[i] > ext_s[pick] : ext_s[i] < ext_s[pick]) begin
            pick = i;
          end
        end
      end
      if (!found) begin
        g.status = ST_NOFIT;
      end else begin
        g.alloc_addr = ext_a[pick];
        ext_a[pick] = ext_a[pick] + sz;
        ext_s[pick] = ext_s[pick] - sz;
        if (ext_s[pick] == 0) drop_extent(pick);
        g.status = ST_DONE;
      end
    end else if (sz != 0) begin
      k = 0;
      while (k < ext_n && ext_a[k] < a) k++;
      prev_adj = (k > 0) && (({1'b0, ext_a[k-1]} + {1'b0, ext_s[k-1]}) == {1'b0, a});
      next_adj = (k < ext_n) && (({1'b0, a} + {1'b0, sz}) == {1'b0, ext_a[k]});
      g.status = ST_DONE;
      if (prev_adj) begin
        ext_s[k-1] = sat_sum(ext_s[k-1], sz);
        if (next_adj) begin
          ext_s[k-1] = sat_sum(ext_s[k-1], ext_s[k]);
          drop_extent(k);
        end
      end else if (next_adj) begin
        ext_a[k] = ext_a[k] - sz;
        ext_s[k] = sat_sum(ext_s[k], sz);
      end else if (ext_n >= MAP_ENTRIES) begin
        g.status = ST_FULL;
      end else begin
        for (int i = ext_n; i > k; i--) begin
          ext_a[i] = ext_a[i-1];
          ext_s[i] = ext_s[i-1];
        end
        ext_a[k] = a;
        ext_s[k] = sz;
        ext_n++;
      end
    end
    g.extent_count = ext_n[6:0];
    return g;
  endfunction

  // valid stays high after acceptance until the next call or drain drops it
  task automatic send_request(logic cmd, val_t a, val_t sz);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.addr <= a;
    in_ch.size <= sz;
    do @(posedge clk); while (!in_ch.ready);
    grants_due.push_back(predict_grant(cmd, a, sz));
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (grants_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
    drain();
    repeat (4 * MAP_ENTRIES + 20) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FIT_MODE) fit_worst = d[0];
    else begin
      if (idx == REG_POOL_BASE) base_reg = d;
      else size_reg = d;
      reload_pool();
    end
  endtask

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= idle_pct);

  always @(posedge clk) begin
    grant_t exp_g;
    if (!rst) begin
      stall_cnt++;
      if (stall_cnt > 20000) begin
        $display("TEST FAILED");
        $finish;
      end
      if (in_ch.valid && in_ch.ready) stall_cnt = 0;
      if (out_ch.valid && out_ch.ready) begin
        stall_cnt = 0;
        n_results++;
        if (grants_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transaction");
        end else begin
          exp_g = grants_due.pop_front();
          if (out_ch.alloc_addr !== exp_g.alloc_addr || out_ch.status !== exp_g.status ||
              out_ch.extent_count !== exp_g.extent_count) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp addr %h st %0d cnt %0d, got addr %h st %0d cnt %0d",
                       exp_g.alloc_addr, exp_g.status, exp_g.extent_count,
                       out_ch.alloc_addr, out_ch.status, out_ch.extent_count);
          end
        end
      end
    end
  end

  task automatic test_directed();
    send_request(CMD_ALLOC, 16'hFFFF, 16'd0);
    send_request(CMD_ALLOC, 16'h0, 16'd100);
    send_request(CMD_ALLOC, 16'h0, 16'hFFFF);
    send_request(CMD_FREE, 16'd0, 16'd0);
    send_request(CMD_FREE, 16'd0, 16'd50);
    send_request(CMD_FREE, 16'd50, 16'd50);
    send_request(CMD_FREE, 16'd5000, 16'd10);
    send_request(CMD_FREE, 16'd4096, 16'd904);
    send_request(CMD_FREE, 16'hFFF0, 16'hFFFF);
    send_request(CMD_ALLOC, 16'h0, 16'd4);
    send_request(CMD_ALLOC, 16'h0, 16'd5010);
    send_request(CMD_ALLOC, 16'h0, 16'd1);
  endtask

  task automatic test_fit_modes();
    write_reg(REG_FIT_MODE, 16'd1);
    write_reg(REG_POOL_BASE, 16'hF000);
    write_reg(REG_POOL_SIZE, 16'h1000);
    send_request(CMD_FREE, 16'h0100, 16'd20);
    send_request(CMD_FREE, 16'h0200, 16'd8);
    send_request(CMD_ALLOC, 16'h0, 16'd8);
    send_request(CMD_ALLOC, 16'h0, 16'h1000);
    write_reg(REG_FIT_MODE, 16'd0);
    send_request(CMD_ALLOC, 16'h0, 16'd8);
    write_reg(REG_POOL_SIZE, 16'd0);
    send_request(CMD_ALLOC, 16'h0, 16'd0);
    send_request(CMD_FREE, 16'h1234, 16'd3);
    write_reg(REG_POOL_BASE, 16'h0000);
    write_reg(REG_POOL_SIZE, 16'hFFFF);
    send_request(CMD_FREE, 16'hFFFF, 16'hFFFF);
  endtask

  // fill the table past its capacity with scattered frees
  task automatic test_full_table();
    write_reg(REG_POOL_BASE, 16'd0);
    write_reg(REG_POOL_SIZE, 16'd0);
    for (int i = 0; i < MAP_ENTRIES + 4; i++) send_request(CMD_FREE, 16'(i * 200), 16'd100);
    send_request(CMD_FREE, 16'd100, 16'd100);
    send_request(CMD_FREE, 16'd60000, 16'd5);
  endtask

  task automatic test_random(int count);
    val_t a, sz;
    int r;
    for (int i = 0; i < count; i++) begin
      if (i % 300 == 0) begin
        write_reg(REG_FIT_MODE, 16'($urandom_range(1)));
        write_reg(REG_POOL_BASE, 16'($urandom));
        write_reg(REG_POOL_SIZE, ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(8192)));
      end
      idle_pct = (i % 400 < 100) ? 0 : 9;
      r = $urandom_range(99);
      if (r < 45) begin
        sz = (r < 5) ? 16'($urandom) : 16'($urandom_range(300));
        send_request(CMD_ALLOC, 16'($urandom), sz);
      end else if (r < 85 && ext_n > 0) begin
        // free a piece adjacent to, or near, an existing extent
        r = $urandom_range(ext_n - 1);
        sz = 16'($urandom_range(1, 64));
        case ($urandom_range(2))
          0: a = ext_a[r] - sz;
          1: a = ext_a[r] + ext_s[r];
          default: a = ext_a[r] + ext_s[r] + 16'($urandom_range(1, 200));
        endcase
        send_request(CMD_FREE, a, sz);
      end else begin
        send_request(CMD_FREE, 16'($urandom), 16'($urandom_range(2) == 0 ? $urandom : $urandom_range(100)));
      end
    end
    idle_pct = 9;
  endtask

  initial begin
    fit_worst = 1'b0;
    base_reg = '0;
    size_reg = 16'd4096;
    reload_pool();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_fit_modes();
    test_full_table();
    test_random(1250);
    drain();
    repeat (4 * MAP_ENTRIES + 20) @(negedge clk);
    if (errors == 0 && grants_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/fma_pkg.sv
rtl/fma_if.sv
rtl/fma_table.sv
rtl/fma_ctrl.sv
rtl/free_map_allocator_best_worst_fit_top.sv
tb/free_map_allocator_best_worst_fit_top_test.sv
